@@ hw/rtl/slri_pkg.sv @@
// shared types, codes and constants for the sorted list insert/remove block
package slri_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned CountOutW   = 5;

  typedef logic signed [ValueW-1:0] value_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic   do_ins;
    logic   do_rem;
    value_t value;
  } slri_ctrl_t;

  // what a cell reports to its right-hand neighbor and the top level
  typedef struct packed {
    logic lt;
    logic match;
  } slri_flags_t;

endpackage

@@ hw/rtl/sorted_list_insert_remove_core.sv @@
// top level of the sorted list insert/remove block: cell chain plus count and result
// the result of a transferred command is registered at the transfer edge and shown with out_valid
// throughput: one command per clock; busy stays low, every cell compares in parallel
// the critical path is one 32-bit compare per cell, an or-reduce of the match flags and a mux
// reset (rst_n low, synchronous) clears the entry count and the result strobe;
// cell contents are not cleared, only cells below the count are ever looked at
// results cannot be stalled: each one is on the out_ ports for exactly one cycle
module sorted_list_insert_remove_core #(
  parameter int unsigned CAPACITY = slri_pkg::DefCapacity
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [4:0]                  out_entry_count
);
  import slri_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  status_t         status_r;
  status_t         status_nxt;

  slri_ctrl_t      ctrl;
  value_t          entries [CAPACITY];
  slri_flags_t     flags   [CAPACITY];
  logic [CAPACITY-1:0] match_vec;

  logic accept;
  logic is_remove;
  logic full;
  logic empty;
  logic found;

  // the chain never needs to hold anything off
  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_remove = (in_command == CMD_REMOVE);
  assign full      = (count_r == CntW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign found     = |match_vec;

  // insert needs room, remove needs a match; otherwise the cells hold
  assign ctrl.do_ins = accept && !is_remove && !full;
  assign ctrl.do_rem = accept && is_remove && found;
  assign ctrl.value  = in_value;

  // the cell chain: left neighbor feeds inserts, right neighbor feeds removes
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   left_lt;
    value_t left_entry;
    value_t right_entry;

    assign occ = (CntW'(i) < count_r);

    if (i == 0) begin : g_first
      // the head acts as if everything to its left is below the value
      assign left_lt    = 1'b1;
      assign left_entry = in_value;
    end else begin : g_mid
      assign left_lt    = flags[i-1].lt;
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // tail slot becomes unused on a remove, its content does not matter
      assign right_entry = entries[i];
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    slri_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ),
      .left_lt    (left_lt),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .entry      (entries[i]),
      .flags      (flags[i])
    );

    assign match_vec[i] = flags[i].match;
  end

  // status and count for the command in flight
  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_valid_nxt = accept;
    if (accept) begin
      if (!is_remove) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + CntW'(1);
        end
      end else begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (found) begin
          status_nxt = ST_REMOVED;
          count_nxt  = count_r - CntW'(1);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
  end

  // the count register already holds the post-command count during the strobe
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_count = CountOutW'(count_r);

endmodule

@@ hw/rtl/slri_cell.sv @@
// one storage cell of the sorted chain: compare, hold, shift left or right
module slri_cell (
  input  logic                clk,
  input  slri_pkg::slri_ctrl_t ctrl,
  input  logic                occ,
  input  logic                left_lt,
  input  slri_pkg::value_t    left_entry,
  input  slri_pkg::value_t    right_entry,
  output slri_pkg::value_t    entry,
  output slri_pkg::slri_flags_t flags
);
  import slri_pkg::*;

  value_t entry_r;
  value_t entry_nxt;

  // occupied and strictly below the command value
  assign flags.lt    = occ && (entry_r < ctrl.value);
  // first entry not below the value, and equal to it
  assign flags.match = occ && left_lt && (entry_r == ctrl.value);
  assign entry       = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.do_ins && !flags.lt) begin
      entry_nxt = left_lt ? ctrl.value : left_entry;
    end else if (ctrl.do_rem && !flags.lt) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ hw/rtl/slri_checker.sv @@
// port-level checks on the sorted list core, attached by bind
module slri_checker #(
  parameter int unsigned CAPACITY = slri_pkg::DefCapacity
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_command,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [4:0]  out_entry_count
);
  import slri_pkg::*;

  // each transfer gives one result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("no result after command transfer");

  // no result without a command
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without command");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_entry_count == CountOutW'(CAPACITY)))
    else $error("full status below capacity");

  // inserts only get insert-side statuses
  a_status_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_INSERT) |=>
      (out_status == ST_INSERTED || out_status == ST_FULL))
    else $error("insert returned a remove status");

endmodule

bind sorted_list_insert_remove_core slri_checker #(.CAPACITY(CAPACITY)) u_slri_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_command     (in_command),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_entry_count(out_entry_count)
);

@@ bench/sorted_list_insert_remove_core_tb.sv @@
// self-checking testbench for the sorted list insert/remove core
module sorted_list_insert_remove_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slri_pkg::*;

  localparam int unsigned CAPACITY    = DefCapacity;
  localparam int          ITEM_TARGET = 950;
  // cycles with neither a command transfer nor a result before the run is abandoned
  localparam int          QUIET_LIMIT = 1000;

  // one queued command plus how the driver should pace it
  typedef struct {
    cmd_t        cmd;
    value_t      value;
    int unsigned idle_pct;     // chance per cycle of leaving start low before it
    bit          drain_first;  // hold it back until every reply has come
  } list_cmd_t;

  // what the core should answer for one command
  typedef struct {
    status_t    status;
    logic [4:0] count;
  } list_reply_t;

  logic         clk;
  logic         rst_n;
  logic         start;
  logic         busy;
  logic         in_command;
  value_t       in_value;
  logic         out_valid;
  logic [2:0]   out_status;
  logic [4:0]   out_entry_count;

  list_cmd_t    cmd_queue [$];     // commands not yet presented
  list_reply_t  replies_due [$];   // predicted replies, oldest first
  value_t       gen_mirror [$];    // unordered copy of the contents, used to aim removes

  // predicted list contents, ascending, only the first held_n are meaningful
  value_t       shadow_list [CAPACITY];
  int           held_n;

  bit           took_item;         // command transfer at the last rising edge
  int           quiet_cycles;
  int           err_count;
  int           n_queued;
  int           status_seen [5];

  sorted_list_insert_remove_core #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // apply one command to the predicted list and return the reply it should give
  function automatic list_reply_t list_apply(cmd_t cmd, value_t v);
    list_reply_t r;
    int          pos;
    pos = 0;
    // first entry that is >= v; signed compare since value_t is signed
    while (pos < held_n && shadow_list[pos] < v) pos++;
    if (cmd == CMD_INSERT) begin
      if (held_n >= CAPACITY) begin
        // full: value dropped, list untouched
        r.status = ST_FULL;
      end else begin
        // goes ahead of any equal entries already held
        for (int k = held_n; k > pos; k--) shadow_list[k] = shadow_list[k-1];
        shadow_list[pos] = v;
        held_n++;
        r.status = ST_INSERTED;
      end
    end else begin
      if (held_n == 0) begin
        r.status = ST_EMPTY;
      end else if (pos < held_n && shadow_list[pos] == v) begin
        // first of the equal entries goes
        for (int k = pos; k + 1 < held_n; k++) shadow_list[k] = shadow_list[k+1];
        held_n--;
        r.status = ST_REMOVED;
      end else begin
        r.status = ST_NOTFOUND;
      end
    end
    r.count = held_n[4:0];
    return r;
  endfunction

  // queue a command and keep the generator's multiset in step with it
  task automatic queue_cmd(cmd_t cmd, value_t v, int unsigned pct, bit drain);
    list_cmd_t c;
    int        idx [$];
    c.cmd         = cmd;
    c.value       = v;
    c.idle_pct    = pct;
    c.drain_first = drain;
    cmd_queue.push_back(c);
    n_queued++;
    if (cmd == CMD_INSERT) begin
      if (gen_mirror.size() < CAPACITY) gen_mirror.push_back(v);
    end else begin
      idx = gen_mirror.find_first_index(x) with (x == v);
      if (idx.size() > 0) gen_mirror.delete(idx[0]);
    end
  endtask

  // driver: presents commands at the falling edge, one start assignment per step
  always @(negedge clk) begin : drive
    list_cmd_t c;
    logic      nxt_start;
    nxt_start = start;
    if (!rst_n) begin
      nxt_start = 1'b0;
    end else begin
      // transfer done at the last rising edge, the slot is free again
      if (start && took_item) nxt_start = 1'b0;
      if (!nxt_start && cmd_queue.size() > 0) begin
        if (cmd_queue[0].drain_first && replies_due.size() > 0) begin
          // pause until the core has answered everything outstanding
        end else if ($urandom_range(99) < cmd_queue[0].idle_pct) begin
          // sender gap
        end else begin
          c = cmd_queue.pop_front();
          nxt_start  = 1'b1;
          in_command <= c.cmd;
          in_value   <= c.value;
        end
      end
    end
    start <= nxt_start;
  end

  // monitor: checks replies, predicts on each command transfer, runs the watchdog
  always @(posedge clk) begin : watch
    list_reply_t due;
    list_reply_t r;
    if (!rst_n) begin
      took_item    = 1'b0;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      // the reply of a command taken at the previous edge is checked before
      // this edge's command is predicted
      if (out_valid) begin
        quiet_cycles = 0;
        if (replies_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected reply status=%0d count=%0d", $time, out_status,
                   out_entry_count);
        end else begin
          due = replies_due.pop_front();
          if (out_status !== due.status) begin
            err_count++;
            $display("%0t: status expected %0d (%s) actual %0d", $time, due.status,
                     due.status.name(), out_status);
          end
          if (out_entry_count !== due.count) begin
            err_count++;
            $display("%0t: entry_count expected %0d actual %0d", $time, due.count,
                     out_entry_count);
          end
        end
      end
      took_item = start && !busy;
      if (took_item) begin
        quiet_cycles = 0;
        r = list_apply(cmd_t'(in_command), in_value);
        status_seen[int'(r.status)]++;
        replies_due.push_back(r);
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("sorted_list_insert_remove_core verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_pct [4];
    int          burst;
    int          len;
    int unsigned ins_pct;
    int unsigned roll;
    cmd_t        cmd;
    value_t      v;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_command = CMD_INSERT;
    in_value   = '0;
    held_n     = 0;
    err_count  = 0;
    n_queued   = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // pacing phases: back to back, sparse, moderate, back to back again
    phase_pct = '{0, 73, 36, 0};

    // directed: empty list, extremes, duplicates, misses, drain back to empty
    queue_cmd(CMD_REMOVE, 32'sd5, 0, 1'b0);                   // remove on empty
    queue_cmd(CMD_INSERT, 32'sh7fff_ffff, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'sh8000_0000, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd0, 0, 1'b0);
    queue_cmd(CMD_INSERT, -32'sd1, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd0, 0, 1'b0);                   // equal value
    queue_cmd(CMD_INSERT, 32'sh7fff_ffff, 0, 1'b0);           // equal to the top
    queue_cmd(CMD_INSERT, 32'sd1, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sd0, 0, 1'b0);                   // first of two equals
    queue_cmd(CMD_REMOVE, 32'sh1234_5678, 0, 1'b0);           // no match
    queue_cmd(CMD_INSERT, -32'sd5, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd7, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sd6, 0, 1'b0);                   // miss between entries
    queue_cmd(CMD_REMOVE, 32'sh8000_0000, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sh7fff_ffff, 0, 1'b0);
    queue_cmd(CMD_REMOVE, -32'sd1, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sd0, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sd7, 0, 1'b0);
    queue_cmd(CMD_REMOVE, -32'sd5, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sd1, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sh7fff_ffff, 0, 1'b0);           // last entry
    queue_cmd(CMD_REMOVE, 32'sh7fff_ffff, 0, 1'b0);           // empty again

    // random bursts: fill toward full, drain toward empty, or mixed
    burst = 0;
    while (n_queued < ITEM_TARGET) begin
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      len = $urandom_range(8, 40);
      for (int i = 0; i < len; i++) begin
        cmd  = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
        roll = $urandom_range(99);
        if (cmd == CMD_REMOVE && gen_mirror.size() > 0 && roll < 75) begin
          // aimed remove of something held
          v = gen_mirror[$urandom_range(gen_mirror.size() - 1)];
        end else if (roll < 35) begin
          case ($urandom_range(5))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2:       v = 32'sd0;
            3:       v = -32'sd1;
            4:       v = 32'sd1;
            default: v = 32'sh8000_0001;
          endcase
        end else if (roll < 55 && gen_mirror.size() > 0) begin
          // duplicate of a held value
          v = gen_mirror[$urandom_range(gen_mirror.size() - 1)];
        end else begin
          v = $urandom;
        end
        // the first command of every sixth burst waits for all replies
        queue_cmd(cmd, v, phase_pct[(n_queued / 240) % 4], (i == 0) && (burst % 6 == 0));
      end
      burst++;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // everything presented, taken and answered, then a few cycles for strays
    while (cmd_queue.size() != 0 || start || replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("commands run: %0d in %0d bursts after the directed set", n_queued, burst);
    $display("replies: %0d inserted, %0d removed, %0d not found, %0d empty, %0d full",
             status_seen[ST_INSERTED], status_seen[ST_REMOVED], status_seen[ST_NOTFOUND],
             status_seen[ST_EMPTY], status_seen[ST_FULL]);
    if (err_count == 0) begin
      $display("sorted_list_insert_remove_core verification clean");
    end else begin
      $display("sorted_list_insert_remove_core verification failed");
    end
    $finish;
  end

endmodule
